>>> rtl/lrusd_pkg.sv
// shared constants and types for the lru stack distance tracker
package lrusd_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int PAGE_W          = 32;
    localparam int CAP_W           = 7;
    localparam int SDEPTH_W        = 6;
    localparam int CAP_RESET       = 64;

    typedef logic [PAGE_W-1:0]   page_t;
    typedef logic [CAP_W-1:0]    cap_t;
    typedef logic [SDEPTH_W-1:0] sdepth_t;

    typedef struct packed {
        logic    hit;
        sdepth_t stack_depth;
    } result_t;

endpackage

>>> rtl/lrusd_if.sv
// valid/ready channel interfaces for page references and results
interface lrusd_page_if;
    logic                 valid;
    logic                 ready;
    lrusd_pkg::page_t     page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
    modport monitor (input valid, input page_number, input ready);
endinterface

interface lrusd_result_if;
    logic                 valid;
    logic                 ready;
    logic                 hit;
    lrusd_pkg::sdepth_t   stack_depth;

    modport source (output valid, output hit, output stack_depth, input ready);
    modport sink (input valid, input hit, input stack_depth, output ready);
    modport monitor (input valid, input hit, input stack_depth, input ready);
endinterface

>>> rtl/lrusd_stack_ram.sv
// recency stack memory, one write and one registered read port
module lrusd_stack_ram #(
    parameter int DEPTH = lrusd_pkg::STACK_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  lrusd_pkg::page_t                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output lrusd_pkg::page_t                      rdata
);

    lrusd_pkg::page_t mem [DEPTH];
    lrusd_pkg::page_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lrusd_ctrl.sv
// scan sequencer: search and shift in one pass, entry count and capacity
module lrusd_ctrl #(
    parameter int DEPTH = lrusd_pkg::STACK_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  lrusd_pkg::page_t                      page_number,
    output logic                                  idle,
    input  logic                                  cap_we,
    input  lrusd_pkg::cap_t                       cap_wdata,
    input  logic                                  res_free,
    output logic                                  res_valid,
    output lrusd_pkg::result_t                    res,
    output logic                                  ram_we,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
    output lrusd_pkg::page_t                      ram_wdata,
    output logic                                  ram_re,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
    input  lrusd_pkg::page_t                      ram_rdata
);

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int MW      = (CW > lrusd_pkg::CAP_W) ? CW : lrusd_pkg::CAP_W;
    localparam int SW      = (CW > lrusd_pkg::SDEPTH_W) ? CW : lrusd_pkg::SDEPTH_W;
    localparam int CAP_RST = (lrusd_pkg::CAP_RESET > DEPTH) ? DEPTH : lrusd_pkg::CAP_RESET;
    localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);
    localparam logic [SW-1:0] SAT_S   = SW'((1 << lrusd_pkg::SDEPTH_W) - 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic             state_reg;
    logic [CW-1:0]    d_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    cap_reg;
    lrusd_pkg::page_t page_reg;
    lrusd_pkg::page_t carry_reg;

    logic             in_range;
    logic             match;
    logic             term;
    logic             step;
    logic [CW-1:0]    d_inc;
    logic [CW-1:0]    count_next;
    logic [CW-1:0]    cap_next;
    logic [MW-1:0]    cap_ext;
    logic [SW-1:0]    d_ext;

    assign in_range = (d_reg != count_reg);
    assign match    = in_range && (ram_rdata == page_reg);
    assign term     = !in_range || match;
    assign step     = (state_reg == S_SCAN) && (!term || res_free);
    assign d_inc    = d_reg + CW'(1);
    assign idle     = (state_reg == S_IDLE);

    // count after this item: unchanged on a hit, grows on a miss until full
    always_comb
    begin
        if (match)
        begin
            count_next = count_reg;
        end
        else if (count_reg < cap_reg)
        begin
            count_next = d_inc;
        end
        else
        begin
            count_next = cap_reg;
        end
    end

    // zero capacity reads as one, anything above the depth as the depth
    always_comb
    begin
        cap_ext = MW'(cap_wdata);
        if (cap_ext == '0)
        begin
            cap_next = CW'(1);
        end
        else if (cap_ext > DEPTH_M)
        begin
            cap_next = CW'(DEPTH);
        end
        else
        begin
            cap_next = cap_ext[CW-1:0];
        end
    end

    // steps move the carried entry one place down; a full miss drops it
    assign ram_we    = step && (in_range || (count_reg < cap_reg));
    assign ram_waddr = d_reg[AW-1:0];
    assign ram_wdata = carry_reg;
    assign ram_re    = accept || (step && !term);
    assign ram_raddr = idle ? '0 : d_inc[AW-1:0];

    assign d_ext     = SW'(d_reg);
    assign res_valid = step && term;

    always_comb
    begin
        res.hit = match;
        if (!match)
        begin
            res.stack_depth = '0;
        end
        else if (d_ext > SAT_S)
        begin
            res.stack_depth = '1;
        end
        else
        begin
            res.stack_depth = d_ext[lrusd_pkg::SDEPTH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cap_reg   <= CW'(CAP_RST);
            d_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SCAN;
                        d_reg     <= '0;
                    end
                end
                S_SCAN:
                begin
                    if (step)
                    begin
                        if (term)
                        begin
                            state_reg <= S_IDLE;
                            count_reg <= count_next;
                        end
                        else
                        begin
                            d_reg <= d_inc;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cap_we)
            begin
                cap_reg <= cap_next;
                if (count_reg > cap_next)
                begin
                    count_reg <= cap_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg  <= page_number;
            carry_reg <= page_number;
        end
        else if (step && !term)
        begin
            carry_reg <= ram_rdata;
        end
    end

endmodule

>>> rtl/lru_stack_distance_tracker_unit.sv
// top level of the lru stack distance tracker
//
//  channel    dir   handshake         payload
//  refs       in    valid / ready     page_number[31:0]
//  results    out   valid / ready     hit, stack_depth[5:0]
//  capacity   in    capacity_we       capacity_wdata[6:0]
//
// a miss scans every held entry, a hit stops at its depth: one memory read per
// entry scanned, compared and written back one place down in the same pass
// reset clears entry count, sets capacity to min(64, STACK_DEPTH); memory not cleared
// a result waits in an output register; a full register stalls only the last scan step
module lru_stack_distance_tracker_unit #(
    parameter int STACK_DEPTH = lrusd_pkg::STACK_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    lrusd_page_if.sink            refs,
    lrusd_result_if.source        results,
    input  logic                  capacity_we,
    input  lrusd_pkg::cap_t       capacity_wdata
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic               accept;
    logic               idle;
    logic               res_free;
    logic               res_valid;
    lrusd_pkg::result_t res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    lrusd_pkg::page_t   ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    lrusd_pkg::page_t   ram_rdata;

    logic               out_valid_reg;
    lrusd_pkg::result_t out_res_reg;

    assign refs.ready = idle;
    assign accept     = refs.valid && idle;
    assign res_free   = !out_valid_reg || results.ready;

    lrusd_ctrl #(
        .DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .page_number (refs.page_number),
        .idle        (idle),
        .cap_we      (capacity_we),
        .cap_wdata   (capacity_wdata),
        .res_free    (res_free),
        .res_valid   (res_valid),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    lrusd_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.hit         = out_res_reg.hit;
    assign results.stack_depth = out_res_reg.stack_depth;

endmodule

>>> rtl/lrusd_checker.sv
// port-level checks for the lru stack distance tracker
module lrusd_checker (
    input logic              clk,
    input logic              rst_n,
    lrusd_page_if.sink       refs,
    lrusd_result_if.source   results
);

    // a held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |=> results.valid)
        else $error("result dropped while stalled");

    // a held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.ready |=>
            $stable(results.hit) && $stable(results.stack_depth))
        else $error("result payload changed while stalled");

    // a miss always reports depth zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && !results.hit |-> results.stack_depth == '0)
        else $error("miss with non-zero depth");

    // one item at a time: the cycle after an accept takes no item
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        refs.valid && refs.ready |=> !refs.ready)
        else $error("second item taken while scan in progress");

endmodule

bind lru_stack_distance_tracker_unit lrusd_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .refs    (refs),
    .results (results)
);

>>> verif/testbench.sv
// self-checking testbench for the lru stack distance tracker
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_PERIOD         = 10;
    localparam int STACK_DEPTH        = lrusd_pkg::STACK_DEPTH_DEF;
    localparam int SCAN_CYCLES        = STACK_DEPTH + 4;
    localparam int WATCHDOG_LIMIT     = 8000;
    localparam int HOLD_OFF_CYCLES    = 400;
    localparam int MAX_MISMATCH_LINES = 50;
    localparam int NOT_HELD           = -1;
    localparam int PHASE_ITEMS        = 92;

    logic             clk;
    logic             rst_n;
    logic             capacity_we;
    lrusd_pkg::cap_t  capacity_wdata;

    lrusd_page_if   refs_ch ();
    lrusd_result_if results_ch ();

    lru_stack_distance_tracker_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .refs           (refs_ch),
        .results        (results_ch),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata)
    );

    // predictor state, most recent page at the front
    lrusd_pkg::page_t   recency_list[$];
    lrusd_pkg::cap_t    capacity_reg;
    lrusd_pkg::result_t expected_results[$];

    int mismatch_count;
    int burst_left;
    int idle_cycles;
    bit hold_off_req;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic int unsigned usable_capacity();
        int unsigned c;
        c = capacity_reg;
        if (c == 0)
            c = 1;
        if (c > STACK_DEPTH)
            c = STACK_DEPTH;
        return c;
    endfunction

    function automatic lrusd_pkg::result_t track_reference(lrusd_pkg::page_t page);
        lrusd_pkg::result_t r;
        int                 depth;
        depth = NOT_HELD;
        foreach (recency_list[i])
        begin
            if (depth == NOT_HELD && recency_list[i] == page)
                depth = i;
        end
        if (depth != NOT_HELD)
        begin
            recency_list.delete(depth);
            recency_list.push_front(page);
            r.hit         = 1'b1;
            r.stack_depth = (depth > 63) ? lrusd_pkg::sdepth_t'(63)
                                         : lrusd_pkg::sdepth_t'(depth);
        end
        else
        begin
            recency_list.push_front(page);
            if (recency_list.size() > usable_capacity())
                void'(recency_list.pop_back());
            r.hit         = 1'b0;
            r.stack_depth = '0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_MISMATCH_LINES)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_page(lrusd_pkg::page_t page);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                refs_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 16);
        end
        refs_ch.valid       <= 1'b1;
        refs_ch.page_number <= page;
        do
            @(posedge clk);
        while (!refs_ch.ready);
        expected_results.push_back(track_reference(page));
        burst_left--;
        @(negedge clk);
    endtask

    // block idle: nothing outstanding and any scan in flight finished
    task automatic wait_drained();
        refs_ch.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (SCAN_CYCLES) @(negedge clk);
    endtask

    task automatic set_capacity(lrusd_pkg::cap_t value);
        wait_drained();
        capacity_we    <= 1'b1;
        capacity_wdata <= value;
        @(negedge clk);
        capacity_we <= 1'b0;
        capacity_reg = value;
        // lowering the capacity trims the least recent pages at once
        while (recency_list.size() > usable_capacity())
            void'(recency_list.pop_back());
    endtask

    task automatic test_hits_and_misses();
        set_capacity(lrusd_pkg::cap_t'(64));
        send_page(32'h0000_0000);
        send_page(32'h0000_0000);   // hit on the most recent page
        send_page(32'hFFFF_FFFF);
        send_page(32'h0000_0000);
        send_page(32'hAAAA_AAAA);
        send_page(32'h5555_5555);
        send_page(32'h0000_0000);
        send_page(32'hFFFF_FFFF);
    endtask

    task automatic test_eviction_and_trim();
        set_capacity(lrusd_pkg::cap_t'(3));
        send_page(32'h5555_5555);
        send_page(32'h1234_5678);
        send_page(32'h0000_0000);
        send_page(32'hAAAA_AAAA);
        send_page(32'h1234_5678);
    endtask

    task automatic test_capacity_bounds();
        // zero behaves as a single entry
        set_capacity(lrusd_pkg::cap_t'(0));
        send_page(32'h8000_0001);
        send_page(32'h8000_0001);
        send_page(32'h7FFF_FFFE);
        // values above the stack depth are clipped to it
        set_capacity(lrusd_pkg::cap_t'(127));
        send_page(32'h7FFF_FFFE);
        send_page(32'h8000_0001);
        send_page(32'h7FFF_FFFE);
    endtask

    task automatic test_output_backpressure();
        set_capacity(lrusd_pkg::cap_t'(8));
        hold_off_req = 1'b1;
        for (int i = 0; i < 14; i++)
            send_page(lrusd_pkg::page_t'($urandom_range(0, 9)));
    endtask

    task automatic test_random_references();
        int               capacities[11];
        lrusd_pkg::page_t pool[$];
        lrusd_pkg::page_t page;
        int               pool_size;
        int               sel;
        capacities = '{1, 64, 2, 127, 0, 7, 65, 33, 64, 16, 0};
        capacities[10] = $urandom_range(0, 127);
        foreach (capacities[p])
        begin
            set_capacity(lrusd_pkg::cap_t'(capacities[p]));
            pool.delete();
            pool_size = usable_capacity() + $urandom_range(0, usable_capacity() / 4 + 2);
            for (int i = 0; i < pool_size; i++)
                pool.push_back(lrusd_pkg::page_t'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 8)
                    page = lrusd_pkg::page_t'($urandom);
                else if (sel < 16 && recency_list.size() != 0)
                    page = recency_list[$];   // deepest held page
                else
                    page = pool[$urandom_range(0, pool.size() - 1)];
                send_page(page);
            end
        end
    endtask

    // receiver: changes its stall pattern every so often
    initial
    begin
        int mode;
        int span;
        int tick;
        results_ch.ready = 1'b0;
        tick = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 200);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    results_ch.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                else
                begin
                    case (mode)
                        0: results_ch.ready <= 1'b1;
                        1: results_ch.ready <= ($urandom_range(0, 3) != 0);
                        2: results_ch.ready <= ($urandom_range(0, 3) == 0);
                        default: results_ch.ready <= (tick % 5 != 0);
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        lrusd_pkg::result_t want;
        if (rst_n && results_ch.valid && results_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result arrived with no item outstanding");
            else
            begin
                want = expected_results.pop_front();
                if (results_ch.hit !== want.hit)
                    report_mismatch($sformatf("hit: got %b, expected %b",
                                              results_ch.hit, want.hit));
                if (results_ch.stack_depth !== want.stack_depth)
                    report_mismatch($sformatf("stack_depth: got %0d, expected %0d",
                                              results_ch.stack_depth, want.stack_depth));
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (refs_ch.valid && refs_ch.ready)
                    || (results_ch.valid && results_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        refs_ch.valid       = 1'b0;
        refs_ch.page_number = '0;
        capacity_we         = 1'b0;
        capacity_wdata      = '0;
        capacity_reg        = lrusd_pkg::cap_t'(lrusd_pkg::CAP_RESET);
        mismatch_count      = 0;
        burst_left          = 0;
        hold_off_req        = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_hits_and_misses();
        test_eviction_and_trim();
        test_capacity_bounds();
        test_output_backpressure();
        test_random_references();

        wait_drained();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
